FILE: sv/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the first-fit free-list allocator.
// Heap geometry, operation codes and the state machine encoding.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned HeapSize   = 4096;
  localparam int unsigned HeaderSize = 16;
  localparam int unsigned AddrW      = 12;   // index into the header store
  localparam int unsigned LinkW      = 13;   // link value, >= HeapSize means none
  localparam int unsigned SizeW      = 13;
  localparam int unsigned StepW      = 14;   // walk step counter, holds HeapSize

  localparam logic [LinkW-1:0] LinkNone = LinkW'(HeapSize);
  localparam logic [SizeW-1:0] HdrSz    = SizeW'(HeaderSize);
  localparam logic [StepW-1:0] StepMax  = StepW'(HeapSize);

  typedef enum logic [1:0] {
    OpAlloc  = 2'd0,
    OpFree   = 2'd1,
    OpReport = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [9:0] {
    StIdle   = 10'b00_0000_0001,
    StRdA    = 10'b00_0000_0010,  // read of current alloc candidate issued
    StAlloc  = 10'b00_0000_0100,  // candidate data valid
    StRdF    = 10'b00_0000_1000,  // freed header valid, head read issued
    StFreeH  = 10'b00_0001_0000,  // head header valid, compare with freed block
    StFreeW  = 10'b00_0010_0000,  // walk step: p data valid
    StFreeQ  = 10'b00_0100_0000,  // q data valid, final merge
    StRpt    = 10'b00_1000_0000,  // report walk data valid
    StWr     = 10'b01_0000_0000,  // second write cycle
    StOut    = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    logic                 status;
    logic [AddrW-1:0]     granted_addr;
    logic [SizeW-1:0]     total_bytes;
    logic [SizeW-1:0]     used_bytes;
    logic [SizeW-1:0]     free_bytes;
  } result_t;

  function automatic logic is_none(input logic [LinkW-1:0] link);
    return link >= LinkNone;
  endfunction

endpackage

FILE: sv/first_fit_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_core
// First-fit heap allocator whose address-ordered free list lives in two
// synchronous header memories (next link and payload size).
// ----------------------------------------------------------------------------
// Channel   Dir   Fields (tdata / tuser, lowest bit first)
// s_axis    in    tdata: request_size[12:0], release_addr[24:13]; tuser: operation
// m_axis    out   tdata: status, granted_addr, total, used, free bytes
//
// Operation: the header memories have one read port with a registered output.
// An allocate reads and then compares each free block it inspects in turn;
// when the chosen block is split, the tail header is written before the
// grant is shown. A free that lands before the head (or on an empty list)
// needs no walk, else it walks the list nodes up to the freed block; a
// report reads each free block in turn. Reset leaves one free block
// spanning the heap; entry 0 is written by a one-cycle boot write. A new
// request is taken only once the output register is empty, in the cycle
// after the previous result was accepted.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_core
  import ffa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // request_size[12:0], release_addr[24:13], zero fill
  input  logic [31:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[0], granted_addr[12:1], total[25:13], used[38:26], free[51:39]
  output logic [55:0] m_axis_tdata
);

  // Header memories, one read and one write port each.
  logic [LinkW-1:0] mem_next [HeapSize];
  logic [SizeW-1:0] mem_size [HeapSize];

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [LinkW-1:0] rd_next_q;
  logic [SizeW-1:0] rd_size_q;

  logic             wn_en, ws_en;
  logic [AddrW-1:0] wn_addr, ws_addr;
  logic [LinkW-1:0] wn_data;
  logic [SizeW-1:0] ws_data;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_next_q <= mem_next[rd_addr];
      rd_size_q <= mem_size[rd_addr];
    end
    if (wn_en) mem_next[wn_addr] <= wn_data;
    if (ws_en) mem_size[ws_addr] <= ws_data;
  end

  state_e           state_q, state_d;
  logic             boot_q;
  logic [LinkW-1:0] head_q, head_d;
  logic [SizeW-1:0] req_q;
  logic [AddrW-1:0] f_q, f_d;          // freed block header
  logic [SizeW-1:0] fsz_q, fsz_d;      // freed block size
  logic [LinkW-1:0] p_q, p_d;          // predecessor / current walk node
  logic             p_head_q, p_head_d; // current alloc node is the head
  logic [LinkW-1:0] pn_q, pn_d;        // next link of p
  logic [SizeW-1:0] psz_q, psz_d;      // size of p
  logic [StepW-1:0] steps_q, steps_d;
  logic [SizeW-1:0] acc_q, acc_d;
  // Pending second write (used when two headers of one memory change).
  logic             w2n_q, w2n_d, w2s_q, w2s_d;
  logic [AddrW-1:0] w2a_q, w2a_d;
  logic [LinkW-1:0] w2nd_q, w2nd_d;
  logic [SizeW-1:0] w2sd_q, w2sd_d;
  result_t          res_q, res_d;
  logic             ovalid_q, ovalid_d;

  logic [SizeW-1:0] in_req;
  logic [AddrW-1:0] in_rel;
  assign in_req = s_axis_tdata[12:0];
  assign in_rel = s_axis_tdata[24:13];

  assign s_axis_tready = (state_q == StIdle) && !boot_q && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {4'd0, res_q.free_bytes, res_q.used_bytes, res_q.total_bytes,
                          res_q.granted_addr, res_q.status};

  // Wide intermediates for block end arithmetic (may exceed the heap).
  logic [14:0] p_end, f_end, tail_w, merged;
  logic [SizeW-1:0] cut_sz;
  logic [14:0] rem_w;

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    f_d      = f_q;
    fsz_d    = fsz_q;
    p_d      = p_q;
    p_head_d = p_head_q;
    pn_d     = pn_q;
    psz_d    = psz_q;
    steps_d  = steps_q;
    acc_d    = acc_q;
    w2n_d    = 1'b0;
    w2s_d    = 1'b0;
    w2a_d    = w2a_q;
    w2nd_d   = w2nd_q;
    w2sd_d   = w2sd_q;
    res_d    = res_q;
    ovalid_d = ovalid_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wn_en    = 1'b0; wn_addr = '0; wn_data = '0;
    ws_en    = 1'b0; ws_addr = '0; ws_data = '0;
    p_end    = 15'(p_q) + 15'(rd_size_q) + 15'(HdrSz);
    f_end    = 15'(f_q) + 15'(fsz_q) + 15'(HdrSz);
    tail_w   = '0;
    merged   = '0;
    cut_sz   = '0;
    rem_w    = 15'(rd_size_q) - 15'(req_q);

    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    if (boot_q) begin
      wn_en = 1'b1; wn_data = LinkNone;
      ws_en = 1'b1; ws_data = SizeW'(HeapSize - HeaderSize);
    end

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          res_d   = '0;
          steps_d = '0;
          acc_d   = '0;
          case (op_e'(s_axis_tuser))
            OpAlloc: begin
              if (is_none(head_q)) begin
                res_d.status = 1'b1;
                ovalid_d = 1'b1;
              end else begin
                rd_en = 1'b1; rd_addr = head_q[AddrW-1:0];
                p_d = head_q; p_head_d = 1'b1;
                state_d = StRdA;
              end
            end
            OpFree: begin
              if (in_rel < AddrW'(HeaderSize)) begin
                ovalid_d = 1'b1;
              end else begin
                f_d = in_rel - AddrW'(HeaderSize);
                rd_en = 1'b1; rd_addr = in_rel - AddrW'(HeaderSize);
                state_d = StRdF;
              end
            end
            OpReport: begin
              res_d.total_bytes = SizeW'(HeapSize);
              if (is_none(head_q)) begin
                res_d.used_bytes = SizeW'(HeapSize);
                ovalid_d = 1'b1;
              end else begin
                rd_en = 1'b1; rd_addr = head_q[AddrW-1:0];
                p_d = head_q;
                state_d = StRpt;
              end
            end
            default: ovalid_d = 1'b1;
          endcase
        end
      end

      StRdA: state_d = StAlloc;

      // rd_* hold the header of candidate p; pn_q is the previous node.
      StAlloc: begin
        if (rd_size_q == req_q) begin
          if (p_head_q) head_d = rd_next_q;
          else begin
            wn_en = 1'b1; wn_addr = pn_q[AddrW-1:0]; wn_data = rd_next_q;
          end
          res_d.granted_addr = p_q[AddrW-1:0] + AddrW'(HeaderSize);
          ovalid_d = 1'b1;
          state_d = StIdle;
        end else if (rd_size_q > req_q && rem_w >= 15'(HdrSz)) begin
          cut_sz = rd_size_q - req_q - HdrSz;
          tail_w = 15'(p_q) + 15'(cut_sz) + 15'(HdrSz);
          ws_en = 1'b1; ws_addr = p_q[AddrW-1:0]; ws_data = cut_sz;
          if (tail_w < 15'(HeapSize)) begin
            wn_en = 1'b1; wn_addr = tail_w[AddrW-1:0]; wn_data = LinkNone;
            w2s_d = 1'b1; w2a_d = tail_w[AddrW-1:0]; w2sd_d = req_q;
          end
          res_d.granted_addr = tail_w[AddrW-1:0] + AddrW'(HeaderSize);
          state_d = (tail_w < 15'(HeapSize)) ? StWr : StOut;
        end else if (is_none(rd_next_q) || (!p_head_q && steps_q == StepMax - 1'b1)) begin
          // The walk past the head gives up after HeapSize list nodes.
          res_d.status = 1'b1;
          ovalid_d = 1'b1;
          state_d = StIdle;
        end else begin
          pn_d = p_q; p_d = rd_next_q; p_head_d = 1'b0;
          if (!p_head_q) steps_d = steps_q + 1'b1;
          rd_en = 1'b1; rd_addr = rd_next_q[AddrW-1:0];
          state_d = StRdA;
        end
      end

      StRdF: begin
        // Header of f is valid now: keep its size, then read the head, or make f the head of an empty list.
        fsz_d = rd_size_q;
        if (is_none(head_q)) begin
          wn_en = 1'b1; wn_addr = f_q; wn_data = LinkNone;
          head_d = LinkW'(f_q);
          state_d = StOut;
        end else begin
          rd_en = 1'b1; rd_addr = head_q[AddrW-1:0];
          state_d = StFreeH;
        end
      end

      // rd_* hold the header of the head block.
      StFreeH: begin
        p_d = head_q;
        if (f_end <= 15'(head_q)) begin
          if (f_end == 15'(head_q)) begin
            wn_en = 1'b1; wn_addr = f_q; wn_data = rd_next_q;
            merged = 15'(fsz_q) + 15'(rd_size_q) + 15'(HdrSz);
            ws_en = 1'b1; ws_addr = f_q; ws_data = merged[SizeW-1:0];
          end else begin
            wn_en = 1'b1; wn_addr = f_q; wn_data = head_q;
          end
          head_d = LinkW'(f_q);
          state_d = StOut;
        end else begin
          state_d = StFreeW;
        end
      end

      // rd_* hold header of p.
      StFreeW: begin
        pn_d = rd_next_q; psz_d = rd_size_q;
        if (is_none(rd_next_q)) begin
          if (p_end == 15'(f_q)) begin
            merged = 15'(rd_size_q) + 15'(fsz_q) + 15'(HdrSz);
            ws_en = 1'b1; ws_addr = p_q[AddrW-1:0]; ws_data = merged[SizeW-1:0];
          end else begin
            wn_en = 1'b1; wn_addr = p_q[AddrW-1:0]; wn_data = LinkW'(f_q);
            w2n_d = 1'b1; w2a_d = f_q; w2nd_d = LinkNone;
          end
          state_d = (p_end == 15'(f_q)) ? StOut : StWr;
        end else if (rd_next_q >= LinkW'(f_q)) begin
          rd_en = 1'b1; rd_addr = rd_next_q[AddrW-1:0];
          state_d = StFreeQ;
        end else if (steps_q == StepMax - 1'b1) begin
          state_d = StOut;
        end else begin
          steps_d = steps_q + 1'b1;
          p_d = rd_next_q;
          rd_en = 1'b1; rd_addr = rd_next_q[AddrW-1:0];
          state_d = StFreeW;
        end
      end

      // rd_* hold header of q = pn_q; psz_q is p's size.
      StFreeQ: begin
        p_end = 15'(p_q) + 15'(psz_q) + 15'(HdrSz);
        if (p_end == 15'(f_q)) begin
          merged = 15'(psz_q) + 15'(fsz_q) + 15'(HdrSz);
          if (merged + 15'(p_q) + 15'(HdrSz) == 15'(pn_q)) begin
            merged = merged + 15'(rd_size_q) + 15'(HdrSz);
            wn_en = 1'b1; wn_addr = p_q[AddrW-1:0]; wn_data = rd_next_q;
          end
          ws_en = 1'b1; ws_addr = p_q[AddrW-1:0]; ws_data = merged[SizeW-1:0];
          state_d = StOut;
        end else begin
          if (f_end == 15'(pn_q)) begin
            merged = 15'(fsz_q) + 15'(rd_size_q) + 15'(HdrSz);
            ws_en = 1'b1; ws_addr = f_q; ws_data = merged[SizeW-1:0];
            wn_en = 1'b1; wn_addr = f_q; wn_data = rd_next_q;
          end else begin
            wn_en = 1'b1; wn_addr = f_q; wn_data = pn_q;
          end
          w2n_d = 1'b1; w2a_d = p_q[AddrW-1:0]; w2nd_d = LinkW'(f_q);
          state_d = StWr;
        end
      end

      // rd_* hold header of p; accumulate free payload.
      StRpt: begin
        acc_d = acc_q + rd_size_q;
        if (is_none(rd_next_q) || steps_q == StepMax - 1'b1) begin
          res_d.free_bytes = acc_q + rd_size_q;
          res_d.used_bytes = SizeW'(HeapSize) - (acc_q + rd_size_q);
          ovalid_d = 1'b1;
          state_d = StIdle;
        end else begin
          steps_d = steps_q + 1'b1;
          p_d = rd_next_q;
          rd_en = 1'b1; rd_addr = rd_next_q[AddrW-1:0];
        end
      end

      StWr: begin
        if (w2n_q) begin
          wn_en = 1'b1; wn_addr = w2a_q; wn_data = w2nd_q;
        end
        if (w2s_q) begin
          ws_en = 1'b1; ws_addr = w2a_q; ws_data = w2sd_q;
        end
        ovalid_d = 1'b1;
        state_d = StIdle;
      end

      StOut: begin
        ovalid_d = 1'b1;
        state_d = StIdle;
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      boot_q   <= 1'b1;
      head_q   <= '0;
      ovalid_q <= 1'b0;
      w2n_q    <= 1'b0;
      w2s_q    <= 1'b0;
      steps_q  <= '0;
    end else begin
      state_q  <= state_d;
      boot_q   <= 1'b0;
      head_q   <= head_d;
      ovalid_q <= ovalid_d;
      w2n_q    <= w2n_d;
      w2s_q    <= w2s_d;
      steps_q  <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q <= in_req;
    end
    f_q      <= f_d;
    fsz_q    <= fsz_d;
    p_q      <= p_d;
    p_head_q <= p_head_d;
    pn_q     <= pn_d;
    psz_q    <= psz_d;
    acc_q    <= acc_d;
    w2a_q    <= w2a_d;
    w2nd_q   <= w2nd_d;
    w2sd_q   <= w2sd_d;
    res_q    <= res_d;
  end

endmodule

FILE: sv/ffa_checker.sv
// ----------------------------------------------------------------------------
// ffa_checker: port-level checks of the allocator core.
// Watches the request and result handshakes and the result fields.
// ----------------------------------------------------------------------------
module ffa_checker
  import ffa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // A result that waits holds its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No new request while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken with result pending");

  // A report carries the heap size in total_bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[25:13] != 13'd0 |->
      m_axis_tdata[25:13] == SizeW'(HeapSize))
    else $error("bad total");

  // A failed allocate grants nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[12:1] == 12'd0)
    else $error("failure with address");

endmodule

bind first_fit_free_list_allocator_core ffa_checker u_ffa_checker (.*);
